// ----- hw/rtl/f2a_pkg.sv -----
// ============================================================================
// f2a_pkg
// Shared types and constants for the float to decimal ASCII converter.
// ============================================================================
package f2a_pkg;

    localparam int INT_DIGITS = 10;
    localparam int IDX_W      = $clog2(INT_DIGITS + 1);

    localparam logic [6:0]  CHAR_ZERO  = 7'h30;
    localparam logic [6:0]  CHAR_DOT   = 7'h2E;
    localparam logic [6:0]  CHAR_MINUS = 7'h2D;
    localparam logic [31:0] INT_SAT    = 32'h7FFF_FFFF;
    localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;
    localparam logic [31:0] TEN        = 32'd10;
    localparam logic [7:0]  EXP_SPECIAL = 8'd255;
    localparam logic [7:0]  EXP_SAT     = 8'd158;
    localparam logic [7:0]  EXP_POINT   = 8'd118;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_INT,
        ST_POINT,
        ST_FRAC
    } f2a_state_t;

    typedef enum logic {
        MODE_DIV10,
        MODE_MUL10
    } f2a_mode_t;

    typedef struct packed {
        logic [31:0] ipart;
        logic [31:0] fpart;
        logic        neg;
        logic [2:0]  ndig;
    } f2a_num_t;

    typedef struct packed {
        logic [3:0]  digit;
        logic [31:0] rest;
    } f2a_step_t;

endpackage

// ----- hw/rtl/float_to_decimal_ascii.sv -----
// ============================================================================
// float_to_decimal_ascii
// Prints an IEEE-754 single as fixed-digit decimal ASCII text.
// ============================================================================
// Input stream: one transaction per number, tdata = value_bits[31:0],
// frac_digits[34:32]. Output stream: one transaction per character,
// tdata[6:0] = ASCII code, tlast on the final character of the number.
// Text: optional '-', integer part (saturated at 2147483647), then '.' and
// zero-padded fraction digits when frac_digits is nonzero.
// Sequence: after acceptance the shared multiplier strips one integer digit
// per cycle, then one character is loaded per cycle into the output register
// while the receiver does not stall it, and the sign state loads nothing when
// there is no sign. s_axis_tready stays low until the last character of the
// number has been loaded.
// Fraction digits come one per unstalled cycle from the same multiplier.
// Reset clears the sequencer and the output valid. A stalled receiver holds
// the output register and the character-emitting states; nothing is dropped.
// ============================================================================
module float_to_decimal_ascii #(
    parameter int MAX_FRAC_DIGITS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value_bits[31:0], frac_digits[34:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // character[6:0]
    output logic        m_axis_tlast
);
    import f2a_pkg::*;

    f2a_state_t state_reg, state_next;
    f2a_num_t   num;
    f2a_step_t  step;
    f2a_mode_t  mode;

    logic [31:0]      int_reg, int_next;
    logic [31:0]      frac_reg, frac_next;
    logic             neg_reg, neg_next;
    logic [2:0]       ndig_reg, ndig_next;
    logic [IDX_W-1:0] icnt_reg, icnt_next;
    logic [2:0]       fcnt_reg, fcnt_next;
    logic [3:0]       digit_buf [INT_DIGITS];
    logic [IDX_W-1:0] rd_idx;

    logic       out_valid_reg;
    logic [6:0] out_char_reg;
    logic       out_last_reg;

    logic       accept;
    logic       advance;
    logic       emit;
    logic [6:0] emit_char;
    logic       emit_last;

    f2a_unpack #(
        .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
    ) u_unpack (
        .value_bits (s_axis_tdata[31:0]),
        .frac_digits(s_axis_tdata[34:32]),
        .num        (num)
    );

    assign mode = (state_reg == ST_FRAC) ? MODE_MUL10 : MODE_DIV10;

    f2a_digit_unit u_digit (
        .operand(mode == MODE_MUL10 ? frac_reg : int_reg),
        .mode   (mode),
        .step   (step)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign advance       = !out_valid_reg || m_axis_tready;
    assign rd_idx        = icnt_reg - IDX_W'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step.rest == 32'd0)
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                if (!neg_reg || advance)
                begin
                    state_next = ST_INT;
                end
            end
            ST_INT:
            begin
                if (advance && icnt_reg == IDX_W'(1))
                begin
                    state_next = (ndig_reg != 3'd0) ? ST_POINT : ST_IDLE;
                end
            end
            ST_POINT:
            begin
                if (advance)
                begin
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                if (advance && fcnt_reg == 3'd1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        emit      = 1'b0;
        emit_char = CHAR_ZERO;
        emit_last = 1'b0;
        int_next  = int_reg;
        frac_next = frac_reg;
        neg_next  = neg_reg;
        ndig_next = ndig_reg;
        icnt_next = icnt_reg;
        fcnt_next = fcnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    int_next  = num.ipart;
                    frac_next = num.fpart;
                    neg_next  = num.neg;
                    ndig_next = num.ndig;
                    icnt_next = '0;
                end
            end
            ST_DIV:
            begin
                int_next  = step.rest;
                icnt_next = icnt_reg + IDX_W'(1);
            end
            ST_SIGN:
            begin
                emit      = neg_reg;
                emit_char = CHAR_MINUS;
            end
            ST_INT:
            begin
                emit      = 1'b1;
                emit_char = CHAR_ZERO + {3'b000, digit_buf[rd_idx]};
                emit_last = (icnt_reg == IDX_W'(1)) && (ndig_reg == 3'd0);
                if (advance)
                begin
                    icnt_next = rd_idx;
                end
            end
            ST_POINT:
            begin
                emit      = 1'b1;
                emit_char = CHAR_DOT;
                fcnt_next = ndig_reg;
            end
            ST_FRAC:
            begin
                emit      = 1'b1;
                emit_char = CHAR_ZERO + {3'b000, step.digit};
                emit_last = (fcnt_reg == 3'd1);
                if (advance)
                begin
                    frac_next = step.rest;
                    fcnt_next = fcnt_reg - 3'd1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit && advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        int_reg  <= int_next;
        frac_reg <= frac_next;
        neg_reg  <= neg_next;
        ndig_reg <= ndig_next;
        icnt_reg <= icnt_next;
        fcnt_reg <= fcnt_next;
        if (state_reg == ST_DIV)
        begin
            digit_buf[icnt_reg] <= step.digit;
        end
        if (emit && advance)
        begin
            out_char_reg <= emit_char;
            out_last_reg <= emit_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_char_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- hw/rtl/f2a_unpack.sv -----
// ============================================================================
// f2a_unpack
// Splits an IEEE-754 single into sign, 32-bit integer part and 32-bit
// fraction of its truncated 32.32 magnitude; clamps the digit count.
// ============================================================================
module f2a_unpack #(
    parameter int MAX_FRAC_DIGITS = 6
) (
    input  logic [31:0]       value_bits,
    input  logic [2:0]        frac_digits,
    output f2a_pkg::f2a_num_t num
);
    import f2a_pkg::*;

    localparam logic [3:0] MaxDig = 4'(MAX_FRAC_DIGITS);

    logic [7:0]  ex;
    logic [7:0]  ex_eff;
    logic [22:0] man;
    logic [23:0] mant;
    logic [63:0] mant64;
    logic [63:0] fixed;
    logic [5:0]  lsh;
    logic [6:0]  rsh;
    logic        is_nan;

    assign ex     = value_bits[30:23];
    assign man    = value_bits[22:0];
    assign ex_eff = (ex == 8'd0) ? 8'd1 : ex;
    assign mant   = {(ex != 8'd0), man};
    assign mant64 = {40'd0, mant};
    assign is_nan = (ex == EXP_SPECIAL) && (man != 23'd0);
    assign lsh    = 6'(ex_eff - EXP_POINT);
    assign rsh    = 7'(EXP_POINT - ex_eff);

    always_comb
    begin
        if (ex_eff >= EXP_POINT)
        begin
            fixed = mant64 << lsh;
        end
        else
        begin
            fixed = mant64 >> rsh;
        end
    end

    always_comb
    begin
        num.neg = value_bits[31] && (value_bits[30:0] != 31'd0) && !is_nan;
        if (is_nan)
        begin
            num.ipart = 32'd0;
            num.fpart = 32'd0;
        end
        else if (ex >= EXP_SAT)
        begin
            num.ipart = INT_SAT;
            num.fpart = 32'd0;
        end
        else
        begin
            num.ipart = fixed[63:32];
            num.fpart = fixed[31:0];
        end
        if ({1'b0, frac_digits} > MaxDig)
        begin
            num.ndig = MaxDig[2:0];
        end
        else
        begin
            num.ndig = frac_digits;
        end
    end

endmodule

// ----- hw/rtl/f2a_digit_unit.sv -----
// ============================================================================
// f2a_digit_unit
// Shared 32x32 multiplier that peels one decimal digit per use: divide by
// ten through the reciprocal (least significant digit of the integer part)
// or multiply by ten (next digit of the fraction).
// ============================================================================
module f2a_digit_unit (
    input  logic [31:0]        operand,
    input  f2a_pkg::f2a_mode_t mode,
    output f2a_pkg::f2a_step_t step
);
    import f2a_pkg::*;

    logic [31:0] coef;
    logic [63:0] prod;
    logic [28:0] quot;
    logic [3:0]  quot_x10;

    assign coef     = (mode == MODE_DIV10) ? RECIP_TEN : TEN;
    assign prod     = {32'd0, operand} * {32'd0, coef};
    assign quot     = prod[63:35];
    assign quot_x10 = {quot[0], 3'b000} + {quot[2:0], 1'b0};

    always_comb
    begin
        if (mode == MODE_DIV10)
        begin
            step.digit = operand[3:0] - quot_x10;
            step.rest  = {3'b000, quot};
        end
        else
        begin
            step.digit = prod[35:32];
            step.rest  = prod[31:0];
        end
    end

endmodule

// ----- bench/f2a_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2a_checker
// Watches both streams of the float to ASCII converter, predicts the text
// of every accepted number and compares each character and its tlast.
// ----------------------------------------------------------------------------
module f2a_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value_bits[31:0], frac_digits[34:32]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // character[6:0]
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending
);
    import f2a_pkg::*;

    localparam int MAX_DIGITS = 6;

    typedef struct {
        logic [6:0] character;
        logic       last_char;
    } glyph_t;

    glyph_t text_q[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic void render_number(input logic [31:0] bits,
                                          input logic [2:0] ndig);
        logic [7:0]  ex;
        logic [22:0] man;
        logic [63:0] mant;
        logic [63:0] fixed;
        logic [63:0] scale;
        logic [63:0] fdec;
        logic [31:0] ipart;
        logic [31:0] fpart;
        logic        neg;
        int          shift;
        int          digits;
        int          len;
        int          n;
        logic [6:0]  text[24];
        logic [6:0]  rev[24];
        logic [63:0] v;
        glyph_t      g;

        ex     = bits[30:23];
        man    = bits[22:0];
        digits = (ndig > MAX_DIGITS) ? MAX_DIGITS : int'(ndig);
        neg    = bits[31] && (bits[30:0] != 31'd0);
        fixed  = 64'd0;

        if (ex == EXP_SPECIAL && man != 23'd0)
        begin
            neg   = 1'b0;
            ipart = 32'd0;
            fpart = 32'd0;
        end
        else if (ex >= EXP_SAT)
        begin
            ipart = INT_SAT;
            fpart = 32'd0;
        end
        else
        begin
            mant  = {40'd0, (ex != 8'd0), man};
            shift = ((ex != 8'd0) ? int'(ex) : 1) - int'(EXP_POINT);
            if (shift >= 0)
                fixed = mant << shift;
            else if (-shift < 64)
                fixed = mant >> (-shift);
            ipart = fixed[63:32];
            fpart = fixed[31:0];
        end

        len = 0;
        if (neg)
        begin
            text[len] = CHAR_MINUS;
            len++;
        end

        v = {32'd0, ipart};
        n = 0;
        do
        begin
            rev[n] = CHAR_ZERO + 7'(v % 10);
            n++;
            v = v / 10;
        end
        while (v != 0);
        for (int i = n - 1; i >= 0; i--)
        begin
            text[len] = rev[i];
            len++;
        end

        if (digits != 0)
        begin
            scale = 64'd1;
            for (int i = 0; i < digits; i++)
                scale = scale * 10;
            fdec = ({32'd0, fpart} * scale) >> 32;
            text[len] = CHAR_DOT;
            len++;
            for (int i = digits - 1; i >= 0; i--)
            begin
                rev[i] = CHAR_ZERO + 7'(fdec % 10);
                fdec   = fdec / 10;
            end
            for (int i = 0; i < digits; i++)
            begin
                text[len] = rev[i];
                len++;
            end
        end

        for (int k = 0; k < len; k++)
        begin
            g.character = text[k];
            g.last_char = (k == len - 1);
            text_q.push_back(g);
        end
    endfunction

    always @(posedge clk)
    begin
        glyph_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (text_q.size() == 0)
                begin
                    $error("unexpected character %h with tlast %b",
                           m_axis_tdata, m_axis_tlast);
                    fail_count++;
                end
                else
                begin
                    want = text_q.pop_front();
                    if (m_axis_tdata[6:0] !== want.character)
                    begin
                        $error("character: expected %h, actual %h",
                               want.character, m_axis_tdata[6:0]);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.last_char)
                    begin
                        $error("last_char: expected %b, actual %b",
                               want.last_char, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                render_number(s_axis_tdata[31:0], s_axis_tdata[34:32]);
            pending = text_q.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the float to ASCII converter: directed corner values, then
// random numbers in three idle phases, with a long output hold-off.
// ----------------------------------------------------------------------------
module tb;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // value_bits[31:0], frac_digits[34:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // character[6:0]
    logic        m_axis_tlast;

    int fail_count;
    int pending;
    int send_idle_pct = 22;
    int recv_idle_pct = 76;
    int stall_left    = 0;

    logic [31:0] dir_bits [23] = '{
        32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBFC0_0000,
        32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
        32'h4F00_0000, 32'h4EFF_FFFF, 32'h0000_0001, 32'h8000_0001,
        32'h2F80_0000, 32'h2F7F_FFFF, 32'h3DCC_CCCD, 32'h3F7F_FFFF,
        32'h42F6_E979, 32'h7F7F_FFFF, 32'h0080_0000, 32'h3E80_0000,
        32'h461C_3FFF, 32'hC974_2400, 32'h3F00_0000
    };
    logic [2:0] dir_digs [23] = '{
        3'd0, 3'd3, 3'd6, 3'd2, 3'd1, 3'd4, 3'd2, 3'd0,
        3'd2, 3'd6, 3'd6, 3'd2, 3'd6, 3'd6, 3'd7, 3'd6,
        3'd3, 3'd5, 3'd1, 3'd5, 3'd6, 3'd0, 3'd1
    };

    float_to_decimal_ascii dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    f2a_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL float_to_decimal_ascii");
        $finish;
    end

    // hold tready low while a stall is counting down
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // tready only moves at the rising edge, so check it at the falling edge
    task automatic send_number(input logic [31:0] bits, input logic [2:0] ndig);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, ndig, bits};
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic drain_text();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        logic        s;
        logic [7:0]  ex;
        logic [22:0] man;
        int          sel;
        s   = 1'($urandom_range(1));
        man = 23'($urandom);
        if ($urandom_range(9) == 0)
            man = $urandom_range(1) ? '1 : '0;
        sel = $urandom_range(99);
        if (sel < 60)
            ex = 8'($urandom_range(160, 105));
        else if (sel < 80)
            ex = 8'($urandom);
        else
            case ($urandom_range(5))
                0:       ex = 8'd0;
                1:       ex = 8'd255;
                2:       ex = 8'd157;
                3:       ex = 8'd158;
                4:       ex = 8'($urandom_range(5, 1));
                default: ex = 8'($urandom_range(127, 120));
            endcase
        return {s, ex, man};
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_number(pick_value(), 3'($urandom_range(7)));
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < 23; i++)
            send_number(dir_bits[i], dir_digs[i]);
        send_random(130);
        drain_text();

        send_idle_pct = 76;
        recv_idle_pct = 22;
        send_random(130);
        drain_text();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_left    = 200;
        send_random(140);
        drain_text();

        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("PASS float_to_decimal_ascii");
        else
            $display("FAIL float_to_decimal_ascii");
        $finish;
    end

endmodule
